// ===== rtl/des_pkg.sv =====
// Shared widths, constants and lane handoff types for the dual encoder speed estimator.
// No dependencies; imported by every module of the block.
package des_pkg;

   localparam int COUNT_W     = 16;
   localparam int SPEED_W     = 21;
   localparam int SCALE_W     = 24;
   localparam int LIMIT_W     = 20;
   localparam int DIST_W      = 48;
   localparam int TOTAL_W     = 16;
   localparam int SCALE_FRAC  = 16;
   localparam int SCALE_SPLIT = 12;
   localparam int XS_W        = 24;
   localparam int XS_MAX      = 1 << (XS_W - 2);
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = SCALE_W;

   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_SCALE  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_SCALE = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_LIMIT = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SLEW_LIMIT  = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_THRESH = CSR_IDX_W'(4);

   typedef struct packed {
      logic load;
      logic tap;
      logic avg;
      logic scl;
      logic xsat;
      logic bld;
      logic lim;
      logic slw;
   } lane_ctl_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] speed;
      logic                      clamped;
   } lane_res_type;

endpackage

// ===== rtl/des_lane.sv =====
// One wheel lane: tap average, scale, blend, clamp and slew limit of the wheel speed.
// Depends on des_pkg; stepped by the control strobes of the top level.
module des_lane import des_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lane_ctl_type              ctl,
   input  logic signed [COUNT_W-1:0] count,
   input  logic [SCALE_W-1:0]        scale,
   input  logic [LIMIT_W-1:0]        speed_limit,
   input  logic [LIMIT_W-1:0]        slew_limit,
   output lane_res_type              res
);

   localparam int K_W    = FRAC_BITS + 1;
   localparam int TAP_W  = COUNT_W + K_W;
   localparam int HI_W   = SCALE_W - SCALE_SPLIT;
   localparam int LO_W   = SCALE_SPLIT;
   localparam int PPH_W  = TAP_W + HI_W + 1;
   localparam int PPL_W  = TAP_W + LO_W + 1;
   localparam int PROD_W = TAP_W + SCALE_W + 1;
   localparam int XW_W   = PROD_W - SCALE_FRAC;
   localparam int BP_W   = SPEED_W + K_W;
   localparam int BX_W   = XS_W + K_W;
   localparam int V_W    = XS_W + 2;
   localparam int D_W    = SPEED_W + 1;

   localparam logic signed [K_W-1:0] K040 = K_W'(((4 << FRAC_BITS) + 5) / 10);
   localparam logic signed [K_W-1:0] K030 = K_W'(((3 << FRAC_BITS) + 5) / 10);
   localparam logic signed [K_W-1:0] K020 = K_W'(((2 << FRAC_BITS) + 5) / 10);
   localparam logic signed [K_W-1:0] K010 = K_W'(((1 << FRAC_BITS) + 5) / 10);
   localparam logic signed [K_W-1:0] K085 = K_W'(((85 << FRAC_BITS) + 50) / 100);
   localparam logic signed [K_W-1:0] K015 = K_W'(((15 << FRAC_BITS) + 50) / 100);

   localparam logic signed [XW_W-1:0] XS_HI = XW_W'(XS_MAX);
   localparam logic signed [XW_W-1:0] XS_LO = -XW_W'(XS_MAX);

   logic signed [COUNT_W-1:0] cur_ff;
   logic signed [COUNT_W-1:0] hist_ff [3];
   logic signed [COUNT_W-1:0] hist_in [3];
   logic signed [TAP_W-1:0]   tap_ff [4];
   logic signed [TAP_W-1:0]   tap_in [4];
   logic signed [TAP_W-1:0]   avg_ff;
   logic signed [TAP_W-1:0]   avg_in;
   logic signed [PPH_W-1:0]   pph_ff;
   logic signed [PPH_W-1:0]   pph_in;
   logic signed [PPL_W-1:0]   ppl_ff;
   logic signed [PPL_W-1:0]   ppl_in;
   logic signed [PROD_W-1:0]  prod;
   logic signed [XW_W-1:0]    xw;
   logic signed [XS_W-1:0]    x_ff;
   logic signed [XS_W-1:0]    x_in;
   logic signed [BP_W-1:0]    bp_ff;
   logic signed [BP_W-1:0]    bp_in;
   logic signed [BX_W-1:0]    bx_ff;
   logic signed [BX_W-1:0]    bx_in;
   logic signed [V_W-1:0]     v;
   logic signed [V_W-1:0]     lim_s;
   logic signed [SPEED_W-1:0] vc_ff;
   logic signed [SPEED_W-1:0] vc_in;
   logic                      clamp_ff;
   logic                      clamp_in;
   logic signed [D_W-1:0]     vd;
   logic signed [D_W-1:0]     pd;
   logic signed [D_W-1:0]     sl;
   logic signed [D_W-1:0]     diff;
   logic signed [SPEED_W-1:0] prev_ff;
   logic signed [SPEED_W-1:0] prev_in;

   always_comb begin
      tap_in[0] = cur_ff * K040;
      tap_in[1] = hist_ff[0] * K030;
      tap_in[2] = hist_ff[1] * K020;
      tap_in[3] = hist_ff[2] * K010;
      avg_in    = tap_ff[0] + tap_ff[1] + tap_ff[2] + tap_ff[3];
      pph_in    = avg_ff * $signed({1'b0, scale[SCALE_W-1:LO_W]});
      ppl_in    = avg_ff * $signed({1'b0, scale[LO_W-1:0]});
   end

   // saturate far outside any speed limit; the clamp gives the same answer
   always_comb begin
      prod = ($signed(PROD_W'(pph_ff)) <<< LO_W) + $signed(PROD_W'(ppl_ff));
      xw   = $signed(XW_W'(prod >>> SCALE_FRAC));
      if (xw > XS_HI) begin
         x_in = $signed(XS_W'(XS_HI));
      end else if (xw < XS_LO) begin
         x_in = $signed(XS_W'(XS_LO));
      end else begin
         x_in = $signed(XS_W'(xw));
      end
      bp_in = prev_ff * K015;
      bx_in = x_ff * K085;
   end

   always_comb begin
      v     = $signed(V_W'(bp_ff >>> FRAC_BITS)) + $signed(V_W'(bx_ff >>> FRAC_BITS));
      lim_s = $signed(V_W'(speed_limit));
      if (v > lim_s) begin
         vc_in    = $signed(SPEED_W'(lim_s));
         clamp_in = 1'b1;
      end else if (v < -lim_s) begin
         vc_in    = $signed(SPEED_W'(-lim_s));
         clamp_in = 1'b1;
      end else begin
         vc_in    = $signed(SPEED_W'(v));
         clamp_in = 1'b0;
      end
   end

   always_comb begin
      vd   = $signed(D_W'(vc_ff));
      pd   = $signed(D_W'(prev_ff));
      sl   = $signed(D_W'(slew_limit));
      diff = vd - pd;
      if (diff > sl) begin
         prev_in = $signed(SPEED_W'(pd + sl));
      end else if (diff < -sl) begin
         prev_in = $signed(SPEED_W'(pd - sl));
      end else begin
         prev_in = vc_ff;
      end
      hist_in[0] = cur_ff;
      hist_in[1] = hist_ff[0];
      hist_in[2] = hist_ff[1];
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cur_ff <= count;
      end
      if (ctl.tap) begin
         tap_ff <= tap_in;
      end
      if (ctl.avg) begin
         avg_ff <= avg_in;
      end
      if (ctl.scl) begin
         pph_ff <= pph_in;
         ppl_ff <= ppl_in;
      end
      if (ctl.xsat) begin
         x_ff <= x_in;
      end
      if (ctl.bld) begin
         bp_ff <= bp_in;
         bx_ff <= bx_in;
      end
      if (ctl.lim) begin
         vc_ff    <= vc_in;
         clamp_ff <= clamp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= '0;
         hist_ff[0] <= '0;
         hist_ff[1] <= '0;
         hist_ff[2] <= '0;
      end else if (ctl.slw) begin
         prev_ff <= prev_in;
         hist_ff <= hist_in;
      end
   end

   assign res.speed   = prev_ff;
   assign res.clamped = clamp_ff;

endmodule

// ===== rtl/des_merge.sv =====
// Merge stage: combines both lane speeds, runs the odometer and the clamp counter,
// and holds the result item. Depends on des_pkg and the lane result type.
module des_merge import des_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  lane_res_type              left,
   input  lane_res_type              right,
   input  logic [LIMIT_W-1:0]        fast_threshold,
   output logic signed [SPEED_W-1:0] left_speed,
   output logic signed [SPEED_W-1:0] right_speed,
   output logic signed [SPEED_W-1:0] combined_speed,
   output logic signed [DIST_W-1:0]  distance_sum,
   output logic [TOTAL_W-1:0]        overspeed_total
);

   logic [SPEED_W-1:0]        mag_l;
   logic [SPEED_W-1:0]        mag_r;
   logic [SPEED_W-1:0]        thr;
   logic signed [SPEED_W:0]   sum_lr;
   logic signed [SPEED_W-1:0] comb_in;
   logic signed [SPEED_W-1:0] left_ff;
   logic signed [SPEED_W-1:0] right_ff;
   logic signed [SPEED_W-1:0] comb_ff;
   logic signed [DIST_W-1:0]  odo_ff;
   logic signed [DIST_W-1:0]  odo_in;
   logic [TOTAL_W:0]          cnt_sum;
   logic [TOTAL_W-1:0]        cnt_ff;
   logic [TOTAL_W-1:0]        cnt_in;

   always_comb begin
      mag_l  = left.speed[SPEED_W-1] ? $unsigned(-left.speed) : $unsigned(left.speed);
      mag_r  = right.speed[SPEED_W-1] ? $unsigned(-right.speed) : $unsigned(right.speed);
      thr    = {1'b0, fast_threshold};
      sum_lr = $signed((SPEED_W + 1)'(left.speed)) + $signed((SPEED_W + 1)'(right.speed));
      if (mag_l >= thr || mag_r >= thr) begin
         comb_in = (mag_r <= mag_l) ? right.speed : left.speed;
      end else begin
         comb_in = sum_lr[SPEED_W:1];
      end
      odo_in  = odo_ff + {{(DIST_W - SPEED_W){comb_in[SPEED_W-1]}}, comb_in};
      cnt_sum = {1'b0, cnt_ff} + (TOTAL_W + 1)'(left.clamped)
              + (TOTAL_W + 1)'(right.clamped);
      cnt_in  = cnt_sum[TOTAL_W] ? '1 : cnt_sum[TOTAL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         left_ff  <= left.speed;
         right_ff <= right.speed;
         comb_ff  <= comb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         odo_ff <= '0;
         cnt_ff <= '0;
      end else if (load) begin
         odo_ff <= odo_in;
         cnt_ff <= cnt_in;
      end
   end

   assign left_speed      = left_ff;
   assign right_speed     = right_ff;
   assign combined_speed  = comb_ff;
   assign distance_sum    = odo_ff;
   assign overspeed_total = cnt_ff;

endmodule

// ===== rtl/dual_encoder_speed_estimator.sv =====
// Dual encoder speed estimator: takes one left/right encoder count pair per item and
// returns filtered wheel speeds, a combined speed, the odometer and the clamp count,
// all Q(FRAC_BITS) except the count. It uses des_pkg, two des_lane copies (the right
// count is negated on entry) and des_merge. One item is in flight at a time: it passes
// the dependent chain of tap products, average, split scale multiply, saturation, blend
// multiply, clamp, slew limit and merge, waiting at the merge while the result side
// stalls. A finished item waits in the output register while the next item is accepted.
// Configuration registers are written through csr_write_en/csr_index/csr_data; to take
// effect on the next item, write them only between items; the block does not check it.
module dual_encoder_speed_estimator import des_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [COUNT_W-1:0]   req_left_count,
   input  logic signed [COUNT_W-1:0]   req_right_count,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [SPEED_W-1:0]   rsp_left_speed,
   output logic signed [SPEED_W-1:0]   rsp_right_speed,
   output logic signed [SPEED_W-1:0]   rsp_combined_speed,
   output logic signed [DIST_W-1:0]    rsp_distance_sum,
   output logic [TOTAL_W-1:0]          rsp_overspeed_total,
   input  logic                        csr_write_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_data
);

   localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(65536);
   localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(524288);
   localparam logic [LIMIT_W-1:0] SLEW_RST  = LIMIT_W'(2621);
   localparam logic [LIMIT_W-1:0] FAST_RST  = LIMIT_W'(262144);

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_TAP  = 9'b000000010,
      ST_AVG  = 9'b000000100,
      ST_SCL  = 9'b000001000,
      ST_XSAT = 9'b000010000,
      ST_BLD  = 9'b000100000,
      ST_LIM  = 9'b001000000,
      ST_SLW  = 9'b010000000,
      ST_CMB  = 9'b100000000
   } state_type;

   state_type                 state_ff;
   state_type                 state_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [SCALE_W-1:0]        left_scale_ff;
   logic [SCALE_W-1:0]        right_scale_ff;
   logic [LIMIT_W-1:0]        speed_limit_ff;
   logic [LIMIT_W-1:0]        slew_limit_ff;
   logic [LIMIT_W-1:0]        fast_thresh_ff;
   logic                      req_take;
   logic                      out_load;
   logic signed [COUNT_W-1:0] right_neg;
   lane_ctl_type              ctl;
   lane_res_type              left_res;
   lane_res_type              right_res;

   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign out_load  = (state_ff == ST_CMB) && (!rsp_valid_ff || !rsp_stall);
   assign right_neg = -req_right_count;

   always_comb begin
      ctl.load = req_take;
      ctl.tap  = (state_ff == ST_TAP);
      ctl.avg  = (state_ff == ST_AVG);
      ctl.scl  = (state_ff == ST_SCL);
      ctl.xsat = (state_ff == ST_XSAT);
      ctl.bld  = (state_ff == ST_BLD);
      ctl.lim  = (state_ff == ST_LIM);
      ctl.slw  = (state_ff == ST_SLW);
   end

   always_comb begin
      unique case (state_ff)
         ST_IDLE: state_in = req_take ? ST_TAP : ST_IDLE;
         ST_TAP:  state_in = ST_AVG;
         ST_AVG:  state_in = ST_SCL;
         ST_SCL:  state_in = ST_XSAT;
         ST_XSAT: state_in = ST_BLD;
         ST_BLD:  state_in = ST_LIM;
         ST_LIM:  state_in = ST_SLW;
         ST_SLW:  state_in = ST_CMB;
         ST_CMB:  state_in = out_load ? ST_IDLE : ST_CMB;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      priority if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_scale_ff  <= SCALE_RST;
         right_scale_ff <= SCALE_RST;
         speed_limit_ff <= LIMIT_RST;
         slew_limit_ff  <= SLEW_RST;
         fast_thresh_ff <= FAST_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_LEFT_SCALE:  left_scale_ff  <= csr_data;
            CSR_RIGHT_SCALE: right_scale_ff <= csr_data;
            CSR_SPEED_LIMIT: speed_limit_ff <= csr_data[LIMIT_W-1:0];
            CSR_SLEW_LIMIT:  slew_limit_ff  <= csr_data[LIMIT_W-1:0];
            CSR_FAST_THRESH: fast_thresh_ff <= csr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   des_lane #(.FRAC_BITS(FRAC_BITS)) u_left (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .count       (req_left_count),
      .scale       (left_scale_ff),
      .speed_limit (speed_limit_ff),
      .slew_limit  (slew_limit_ff),
      .res         (left_res)
   );

   des_lane #(.FRAC_BITS(FRAC_BITS)) u_right (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .count       (right_neg),
      .scale       (right_scale_ff),
      .speed_limit (speed_limit_ff),
      .slew_limit  (slew_limit_ff),
      .res         (right_res)
   );

   des_merge u_merge (
      .clock           (clock),
      .reset           (reset),
      .load            (out_load),
      .left            (left_res),
      .right           (right_res),
      .fast_threshold  (fast_thresh_ff),
      .left_speed      (rsp_left_speed),
      .right_speed     (rsp_right_speed),
      .combined_speed  (rsp_combined_speed),
      .distance_sum    (rsp_distance_sum),
      .overspeed_total (rsp_overspeed_total)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/des_checker.sv =====
// Port-level checks for the dual encoder speed estimator, attached by bind.
// Depends on des_pkg and the top level's port names.
module des_checker import des_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic signed [SPEED_W-1:0] rsp_left_speed,
   input logic signed [SPEED_W-1:0] rsp_right_speed,
   input logic signed [SPEED_W-1:0] rsp_combined_speed,
   input logic signed [DIST_W-1:0]  rsp_distance_sum,
   input logic [TOTAL_W-1:0]        rsp_overspeed_total
);

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted while another is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_combined_speed)
                                    && $stable(rsp_distance_sum)))
      else $error("stalled result item changed");

   a_combined_between: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_combined_speed >= rsp_left_speed
                      || rsp_combined_speed >= rsp_right_speed)
                     && (rsp_combined_speed <= rsp_left_speed
                         || rsp_combined_speed <= rsp_right_speed)))
      else $error("combined speed outside the wheel speeds");

   a_odometer_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(rsp_distance_sum)) |->
         (rsp_valid && rsp_distance_sum == $past(rsp_distance_sum)
            + {{(DIST_W - SPEED_W){rsp_combined_speed[SPEED_W-1]}}, rsp_combined_speed}))
      else $error("odometer moved by other than the combined speed");

   a_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> rsp_overspeed_total >= $past(rsp_overspeed_total))
      else $error("clamp count decreased");

endmodule

bind dual_encoder_speed_estimator des_checker u_des_checker (.*);

// ===== bench/dual_encoder_speed_estimator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for dual_encoder_speed_estimator: directed and random encoder count
// items, a bit-exact speed predictor and an in-order scoreboard on the result channel.
// Depends on des_pkg and the block's RTL.
module dual_encoder_speed_estimator_tb import des_pkg::*; ();

   localparam int     FRAC_BITS  = 16;
   localparam int     IDLE_LIMIT = 5000;
   localparam int     MAX_PRINTS = 40;
   localparam longint TAP0     = ((longint'(4) << FRAC_BITS) + 5) / 10;
   localparam longint TAP1     = ((longint'(3) << FRAC_BITS) + 5) / 10;
   localparam longint TAP2     = ((longint'(2) << FRAC_BITS) + 5) / 10;
   localparam longint TAP3     = ((longint'(1) << FRAC_BITS) + 5) / 10;
   localparam longint TAKE_NEW = ((longint'(85) << FRAC_BITS) + 50) / 100;
   localparam longint KEEP_OLD = ((longint'(15) << FRAC_BITS) + 50) / 100;
   localparam longint X_LIMIT  = longint'(1) << 40;

   localparam int REG_UNUSED_FIRST = 5;
   localparam int REG_UNUSED_LAST  = 7;

   localparam logic [CSR_DATA_W-1:0] DEF_SCALE     = 24'd65536;
   localparam logic [CSR_DATA_W-1:0] DEF_LIMIT     = 24'd524288;
   localparam logic [CSR_DATA_W-1:0] DEF_SLEW      = 24'd2621;
   localparam logic [CSR_DATA_W-1:0] DEF_THRESHOLD = 24'd262144;
   localparam logic [CSR_DATA_W-1:0] SCALE_MAX     = 24'hFFFFFF;
   localparam logic [CSR_DATA_W-1:0] LIMIT_MAX     = 24'h0FFFFF;

   typedef struct packed {
      logic signed [SPEED_W-1:0] left_speed;
      logic signed [SPEED_W-1:0] right_speed;
      logic signed [SPEED_W-1:0] combined_speed;
      logic signed [DIST_W-1:0]  distance_sum;
      logic [TOTAL_W-1:0]        overspeed_total;
   } speed_report_type;

   logic                       clock           = 1'b0;
   logic                       reset           = 1'b1;
   logic                       req_valid       = 1'b0;
   logic signed [COUNT_W-1:0]  req_left_count  = '0;
   logic signed [COUNT_W-1:0]  req_right_count = '0;
   logic                       rsp_stall       = 1'b0;
   logic                       csr_write_en    = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index       = '0;
   logic [CSR_DATA_W-1:0]      csr_data        = '0;
   logic                       req_stall;
   logic                       rsp_valid;
   logic signed [SPEED_W-1:0]  rsp_left_speed;
   logic signed [SPEED_W-1:0]  rsp_right_speed;
   logic signed [SPEED_W-1:0]  rsp_combined_speed;
   logic signed [DIST_W-1:0]   rsp_distance_sum;
   logic [TOTAL_W-1:0]         rsp_overspeed_total;

   longint             count_hist [2][3]  = '{default: 0};
   longint             prev_speed [2]     = '{0, 0};
   logic [SCALE_W-1:0] cfg_scale [2]      = '{DEF_SCALE, DEF_SCALE};
   logic [LIMIT_W-1:0] cfg_speed_limit    = DEF_LIMIT[LIMIT_W-1:0];
   logic [LIMIT_W-1:0] cfg_slew_limit     = DEF_SLEW[LIMIT_W-1:0];
   logic [LIMIT_W-1:0] cfg_fast_threshold = DEF_THRESHOLD[LIMIT_W-1:0];
   logic [DIST_W-1:0]  odometer           = '0;
   logic [TOTAL_W-1:0] clamp_total        = '0;

   speed_report_type pending_reports [$];
   int               mismatches      = 0;
   int               items_accepted  = 0;
   int               results_checked = 0;
   int               csr_writes      = 0;
   int               idle_cycles     = 0;
   int               hold_request    = 0;
   int               hold_left       = 0;
   bit               steady_flow     = 1'b0;

   dual_encoder_speed_estimator #(.FRAC_BITS(FRAC_BITS)) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_left_count      (req_left_count),
      .req_right_count     (req_right_count),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_left_speed      (rsp_left_speed),
      .rsp_right_speed     (rsp_right_speed),
      .rsp_combined_speed  (rsp_combined_speed),
      .rsp_distance_sum    (rsp_distance_sum),
      .rsp_overspeed_total (rsp_overspeed_total),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #5 clock = ~clock;

   function automatic longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_word();
      return CSR_DATA_W'($urandom);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_span(input int unsigned lo,
                                                      input int unsigned hi);
      return CSR_DATA_W'($urandom_range(hi, lo));
   endfunction

   function automatic longint filter_wheel(int w, longint cur);
      longint avg, x, v, lim, slew, prev;
      prev = prev_speed[w];
      lim  = longint'(cfg_speed_limit);
      slew = longint'(cfg_slew_limit);
      avg  = TAP0 * cur + TAP1 * count_hist[w][0] + TAP2 * count_hist[w][1]
           + TAP3 * count_hist[w][2];
      x = (avg * longint'(cfg_scale[w])) >>> SCALE_FRAC;
      if (x > X_LIMIT) x = X_LIMIT;
      else if (x < -X_LIMIT) x = -X_LIMIT;
      v = ((prev * KEEP_OLD) >>> FRAC_BITS) + ((x * TAKE_NEW) >>> FRAC_BITS);
      if (v > lim || v < -lim) begin
         v = (v > lim) ? lim : -lim;
         if (clamp_total != '1) clamp_total++;
      end
      if (v - prev > slew) v = prev + slew;
      else if (v - prev < -slew) v = prev - slew;
      count_hist[w][2] = count_hist[w][1];
      count_hist[w][1] = count_hist[w][0];
      count_hist[w][0] = cur;
      prev_speed[w] = v;
      return v;
   endfunction

   function automatic speed_report_type estimate_speeds(logic signed [COUNT_W-1:0] left_cnt,
                                                        logic signed [COUNT_W-1:0] right_cnt);
      logic signed [COUNT_W-1:0] right_neg;
      longint                    l, r, c, thr;
      speed_report_type          rep;
      right_neg = -right_cnt;
      thr = longint'(cfg_fast_threshold);
      l = filter_wheel(0, longint'(left_cnt));
      r = filter_wheel(1, longint'(right_neg));
      if (magnitude(l) >= thr || magnitude(r) >= thr)
         c = (magnitude(r) <= magnitude(l)) ? r : l;
      else
         c = (l + r) >>> 1;
      odometer = odometer + c[DIST_W-1:0];
      rep.left_speed      = l[SPEED_W-1:0];
      rep.right_speed     = r[SPEED_W-1:0];
      rep.combined_speed  = c[SPEED_W-1:0];
      rep.distance_sum    = odometer;
      rep.overspeed_total = clamp_total;
      return rep;
   endfunction

   function automatic logic signed [COUNT_W-1:0] pick_count();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0:       return 16'sh7FFF;
               1:       return 16'sh8000;
               2:       return '0;
               3:       return '1;
               default: return 16'sd1;
            endcase
         end
         1, 2, 3, 4: return COUNT_W'($urandom_range(0, 600) - 300);
         5, 6, 7:    return COUNT_W'($urandom_range(0, 8000) - 4000);
         default:    return COUNT_W'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("mismatch at %0t ns: %s", $time, msg);
   endtask

   // update the predictor on every accepted item and register write
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         pending_reports.push_back(estimate_speeds(req_left_count, req_right_count));
         items_accepted++;
      end
      if (!reset && csr_write_en) begin
         csr_writes++;
         case (csr_index)
            CSR_LEFT_SCALE:  cfg_scale[0]       = csr_data[SCALE_W-1:0];
            CSR_RIGHT_SCALE: cfg_scale[1]       = csr_data[SCALE_W-1:0];
            CSR_SPEED_LIMIT: cfg_speed_limit    = csr_data[LIMIT_W-1:0];
            CSR_SLEW_LIMIT:  cfg_slew_limit     = csr_data[LIMIT_W-1:0];
            CSR_FAST_THRESH: cfg_fast_threshold = csr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always @(posedge clock) begin : check_results
      speed_report_type got, want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got = '{rsp_left_speed, rsp_right_speed, rsp_combined_speed, rsp_distance_sum,
                 rsp_overspeed_total};
         if (pending_reports.size() == 0) begin
            report_mismatch($sformatf("result with no item pending, left_speed %0d",
                                      got.left_speed));
         end else begin
            want = pending_reports.pop_front();
            results_checked++;
            if (got.left_speed !== want.left_speed)
               report_mismatch($sformatf("result %0d left_speed %0d, want %0d",
                                         results_checked, got.left_speed, want.left_speed));
            if (got.right_speed !== want.right_speed)
               report_mismatch($sformatf("result %0d right_speed %0d, want %0d",
                                         results_checked, got.right_speed, want.right_speed));
            if (got.combined_speed !== want.combined_speed)
               report_mismatch($sformatf("result %0d combined_speed %0d, want %0d",
                                         results_checked, got.combined_speed,
                                         want.combined_speed));
            if (got.distance_sum !== want.distance_sum)
               report_mismatch($sformatf("result %0d distance_sum %0d, want %0d",
                                         results_checked, got.distance_sum,
                                         want.distance_sum));
            if (got.overspeed_total !== want.overspeed_total)
               report_mismatch($sformatf("result %0d overspeed_total %0d, want %0d",
                                         results_checked, got.overspeed_total,
                                         want.overspeed_total));
         end
      end
   end

   // result side: random stalls plus requested long hold-offs
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady_flow && ($urandom_range(0, 99) < 26);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_counts(input logic signed [COUNT_W-1:0] left_cnt,
                              input logic signed [COUNT_W-1:0] right_cnt);
      @(negedge clock);
      while (!steady_flow && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_left_count  <= left_cnt;
      req_right_count <= right_cnt;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] left_scale,
                            input logic [CSR_DATA_W-1:0] right_scale,
                            input logic [CSR_DATA_W-1:0] speed_limit,
                            input logic [CSR_DATA_W-1:0] slew_limit,
                            input logic [CSR_DATA_W-1:0] fast_threshold);
      wait_for_results();
      write_csr(CSR_LEFT_SCALE, left_scale);
      write_csr(CSR_RIGHT_SCALE, right_scale);
      write_csr(CSR_SPEED_LIMIT, speed_limit);
      write_csr(CSR_SLEW_LIMIT, slew_limit);
      write_csr(CSR_FAST_THRESH, fast_threshold);
   endtask

   task automatic run_counts(input int n);
      repeat (n) send_counts(pick_count(), pick_count());
      wait_for_results();
   endtask

   task automatic test_directed();
      send_counts(16'sd0, 16'sd0);
      send_counts(16'sh7FFF, 16'sh8000);
      send_counts(16'sh8000, 16'sh7FFF);
      send_counts(16'sh8000, 16'sh8000);
      send_counts(16'sh7FFF, 16'sh7FFF);
      send_counts(16'sd1, -16'sd1);
      send_counts(-16'sd1, 16'sd0);
      // min-magnitude select with equal magnitudes of opposite sign
      configure(DEF_SCALE, DEF_SCALE, LIMIT_MAX, LIMIT_MAX, '0);
      repeat (4) send_counts(16'sd100, 16'sd100);
      repeat (2) send_counts(-16'sd500, -16'sd200);
      // mean path with odd sums, speed limit and slew written with bits above the width
      configure(DEF_SCALE, DEF_SCALE, SCALE_MAX, SCALE_MAX, LIMIT_MAX);
      send_counts(16'sd3, 16'sd0);
      send_counts(-16'sd3, 16'sd0);
      repeat (2) send_counts(16'sh7FFF, 16'sh8000);
      repeat (2) send_counts(16'sh8000, 16'sh7FFF);
      wait_for_results();
   endtask

   task automatic test_config_sweep();
      configure(DEF_SCALE, DEF_SCALE, DEF_LIMIT, DEF_SLEW, DEF_THRESHOLD);
      run_counts(130);
      configure(rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
      run_counts(130);
      configure(SCALE_MAX, SCALE_MAX, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX);
      run_counts(130);
      configure('0, '0, rand_word(), rand_word(), rand_word());
      run_counts(60);
      configure(rand_span(0, 1 << 17), rand_span(0, 1 << 17), '0, rand_word(), rand_word());
      run_counts(100);
      configure(rand_span(0, 1 << 17), rand_span(0, 1 << 17), rand_word(), '0, rand_word());
      run_counts(80);
      configure(rand_span(0, 1 << 18), rand_span(0, 1 << 18), rand_span(0, 1 << 20),
                LIMIT_MAX, '0);
      run_counts(130);
      steady_flow = 1'b1;
      configure(rand_span(0, 1 << 18), rand_span(0, 1 << 18), rand_span(1 << 16, 1 << 20),
                rand_span(0, 1 << 16), rand_span(0, 1 << 19));
      repeat (3) write_csr(CSR_IDX_W'($urandom_range(REG_UNUSED_LAST, REG_UNUSED_FIRST)),
                           rand_word());
      run_counts(130);
      steady_flow = 1'b0;
   endtask

   task automatic test_backpressure();
      configure(rand_span(1 << 15, 1 << 17), rand_span(1 << 15, 1 << 17), LIMIT_MAX,
                rand_span(0, 1 << 16), rand_span(0, 1 << 19));
      hold_request = 300;
      run_counts(40);
      hold_request = 150;
      run_counts(20);
   endtask

   task automatic test_clamp_heavy();
      int a, b;
      configure(DEF_SCALE, DEF_SCALE, rand_span(0, 255), LIMIT_MAX, rand_span(0, 255));
      steady_flow = 1'b1;
      repeat (100) begin
         a = $urandom_range(32767, 1024);
         b = $urandom_range(32767, 1024);
         send_counts(COUNT_W'($urandom_range(0, 1) ? -a : a),
                     COUNT_W'($urandom_range(0, 1) ? -b : b));
      end
      steady_flow = 1'b0;
      wait_for_results();
   endtask

   task automatic test_random_tail();
      configure(DEF_SCALE, DEF_SCALE, DEF_LIMIT, DEF_SLEW, DEF_THRESHOLD);
      run_counts(120);
      configure(rand_span(0, 1 << 18), rand_span(0, 1 << 18), rand_word(), rand_word(),
                rand_span(0, 1 << 19));
      run_counts(120);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_config_sweep();
      test_backpressure();
      test_clamp_heavy();
      test_random_tail();
      wait_for_results();
      repeat (30) @(posedge clock);
      if (pending_reports.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_reports.size()));
      $display("ran %0d items, checked %0d results, %0d register writes",
               items_accepted, results_checked, csr_writes);
      $display("clamp counter reached %0d; directed, sweep, hold-off and heavy clamp phases",
               clamp_total);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/des_pkg.sv
rtl/des_lane.sv
rtl/des_merge.sv
rtl/dual_encoder_speed_estimator.sv
rtl/des_checker.sv
bench/dual_encoder_speed_estimator_tb.sv
